>>> design/sgs_pkg.sv
package sgs_pkg;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CALC = 6'b000010,
        ST_SQX  = 6'b000100,
        ST_SQY  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    localparam logic [2:0] ADDR_WIDTH_REG  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT_REG = 3'd4;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [10:0] HEIGHT_RESET = 11'd480;

    localparam logic [16:0] TAN_LO = 17'd27146;
    localparam logic [17:0] TAN_HI = 18'd158218;

    localparam logic [1:0] SEC_HORIZ = 2'd0;
    localparam logic [1:0] SEC_DIAG45 = 2'd1;
    localparam logic [1:0] SEC_VERT = 2'd2;
    localparam logic [1:0] SEC_DIAG135 = 2'd3;

    localparam int SQ_BITS = 21;

endpackage

>>> design/sobel_gradient_sector_unit.sv
// Streaming 3x3 Sobel gradient unit. Pixels enter in raster order on the slave stream, with
// tuser high on the first pixel of a frame; each pixel gives one result on the master stream for
// the window centred one row and one column back, with the gradients, the floor of the square
// root of the squared magnitude and a 45-degree direction sector (zero fields when the centre is
// not interior). Each pixel passes through a line-store read, a window and write-back step, the
// squaring of x and then of y, 11 steps of the bit-pair square-root loop and the output register
// load. The output register lets the next pixel enter while a result waits.
// The line stores are single memories per row and need no clearing after reset.
module sobel_gradient_sector_unit
    import sgs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // valid_res, center_col, center_row, grad_x, grad_y, magnitude, sector
    output logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    state_t state_reg, state_next;

    logic [10:0] width_reg, height_reg;
    logic [AW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [7:0] win_reg [6];
    logic [7:0] mem_a [MAX_WIDTH];
    logic [7:0] mem_b [MAX_WIDTH];
    logic [7:0] rd_a_reg, rd_b_reg;
    logic [7:0] pix_reg;
    logic [AW-1:0] idx_reg;
    logic [9:0] ccol_reg, crow_reg;
    logic valid_reg;
    logic signed [10:0] gx_reg, gy_reg;
    logic [9:0] ax_reg, ay_reg;
    logic sec_lo_reg;
    logic [1:0] sec_reg;
    logic [SQ_BITS-1:0] val_reg, res_reg, bit_reg;
    logic out_valid_reg;
    logic [55:0] out_data_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic accept;
    logic [AW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [AW:0] col_inc;
    logic [RW:0] row_inc;
    logic [AW-1:0] col_new;
    logic [RW-1:0] row_new;
    logic signed [11:0] t0, t1, t2, m0, m2, b0, b1, b2, gx_w, gy_w;
    logic [19:0] sq_w;
    logic [25:0] lhs_w;
    logic [24:0] lo_w;
    logic [27:0] hi_w;
    logic [SQ_BITS-1:0] trial_w;
    logic load_out;

    assign pready = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    always_comb
    begin
        if (width_reg < 11'd3)
            w_eff = WW'(3);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg < 11'd3)
            h_eff = HW'(3);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    always_comb
    begin
        case (paddr)
            ADDR_WIDTH_REG:  prdata = {21'd0, width_reg};
            ADDR_HEIGHT_REG: prdata = {21'd0, height_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr == ADDR_WIDTH_REG)
                width_reg <= pwdata[10:0];
            else if (paddr == ADDR_HEIGHT_REG)
                height_reg <= pwdata[10:0];
        end
    end

    // advance position counters
    always_comb
    begin
        col_cur = s_tuser ? '0 : col_reg;
        row_cur = s_tuser ? '0 : row_reg;
        col_inc = {1'b0, col_cur} + 1'b1;
        row_inc = {1'b0, row_cur} + 1'b1;
        col_new = col_inc[AW-1:0];
        row_new = row_cur;
        if (32'(col_inc) >= 32'(w_eff))
        begin
            col_new = '0;
            row_new = (32'(row_inc) >= 32'(h_eff)) ? '0 : row_inc[RW-1:0];
        end
        else if (32'(row_cur) >= 32'(h_eff))
            row_new = '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_a_reg <= mem_a[col_cur];
            rd_b_reg <= mem_b[col_cur];
        end
        if (state_reg == ST_CALC)
        begin
            mem_a[idx_reg] <= pix_reg;
            mem_b[idx_reg] <= rd_a_reg;
        end
    end

    always_comb
    begin
        t0 = {4'd0, win_reg[0]};
        t1 = {4'd0, win_reg[1]};
        t2 = {4'd0, rd_b_reg};
        m0 = {4'd0, win_reg[2]};
        m2 = {4'd0, rd_a_reg};
        b0 = {4'd0, win_reg[4]};
        b1 = {4'd0, win_reg[5]};
        b2 = {4'd0, pix_reg};
        gx_w = (t0 + (m0 <<< 1) + b0) - (t2 + (m2 <<< 1) + b2);
        gy_w = (t0 + (t1 <<< 1) + t2) - (b0 + (b1 <<< 1) + b2);
        sq_w = (state_reg == ST_SQX) ? ax_reg * ax_reg : ay_reg * ay_reg;
        lhs_w = {ay_reg, 16'd0};
        lo_w = TAN_LO * ax_reg;
        hi_w = TAN_HI * ax_reg;
        trial_w = res_reg + bit_reg;
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CALC;
            ST_CALC: state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_ROOT;
            ST_ROOT: if (bit_reg[0]) state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                col_reg <= col_new;
                row_reg <= row_new;
            end
            if (state_reg == ST_CALC)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= rd_b_reg;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= rd_a_reg;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= pix_reg;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                pix_reg   <= s_tdata;
                idx_reg   <= col_cur;
                ccol_reg  <= 10'(32'(col_cur) - 1);
                crow_reg  <= 10'(32'(row_cur) - 1);
                valid_reg <= (col_cur >= AW'(2)) && (32'(row_cur) >= 2)
                             && (32'(col_cur) < 32'(w_eff))
                             && (32'(row_cur) < 32'(h_eff));
            end
            ST_CALC:
            begin
                gx_reg <= 11'(gx_w);
                gy_reg <= 11'(gy_w);
                ax_reg <= gx_w[11] ? 10'(-gx_w) : 10'(gx_w);
                ay_reg <= gy_w[11] ? 10'(-gy_w) : 10'(gy_w);
            end
            ST_SQX:
            begin
                val_reg    <= SQ_BITS'(sq_w);
                sec_lo_reg <= {6'd0, lhs_w} < {7'd0, lo_w};
            end
            ST_SQY:
            begin
                val_reg <= val_reg + SQ_BITS'(sq_w);
                res_reg <= '0;
                bit_reg <= SQ_BITS'(1) << (SQ_BITS - 1);
                if ((ax_reg == 10'd0 && ay_reg == 10'd0) || sec_lo_reg)
                    sec_reg <= SEC_HORIZ;
                else if ({2'd0, lhs_w} >= hi_w)
                    sec_reg <= SEC_VERT;
                else if (gx_reg[10] == gy_reg[10])
                    sec_reg <= SEC_DIAG45;
                else
                    sec_reg <= SEC_DIAG135;
            end
            ST_ROOT:
            begin
                if (val_reg >= trial_w)
                begin
                    val_reg <= val_reg - trial_w;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            if (valid_reg)
                out_data_reg <= {sec_reg, res_reg[10:0], gy_reg, gx_reg,
                                 crow_reg, ccol_reg, 1'b1};
            else
                out_data_reg <= 56'd0;
        end
    end

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a pixel is in flight");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata == 56'd0)
        else $error("non-interior result carries data");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[53:43] <= 11'd1442)
        else $error("magnitude out of range");

endmodule

>>> tb/sobel_gradient_sector_check.sv
`timescale 1ns / 100ps

module sobel_gradient_sector_check
    import sgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0]         sector;
        logic [10:0]        magnitude;
        logic signed [10:0] grad_y;
        logic signed [10:0] grad_x;
        logic [9:0]         center_row;
        logic [9:0]         center_col;
        logic               valid_res;
    } gradient_t;

    logic [7:0]  row_above [1024];
    logic [7:0]  row_two_above [1024];
    logic [7:0]  window [6];
    int unsigned col_cnt;
    int unsigned row_cnt;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    gradient_t   pending_grads [$];

    initial
    begin
        for (int i = 0; i < 1024; i++)
        begin
            row_above[i] = 8'd0;
            row_two_above[i] = 8'd0;
        end
    end

    function automatic int unsigned floor_sqrt(int unsigned v);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = 2048;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic gradient_t sobel_step(logic [7:0] pix, logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int t0, t1, t2, m0, m2, b0, b1, b2;
        int gx, gy, ax, ay;
        longint lhs;
        gradient_t r;
        w = (width_reg < 3) ? 3 : ((width_reg > 1024) ? 1024 : width_reg);
        h = (height_reg < 3) ? 3 : ((height_reg > 1024) ? 1024 : height_reg);
        if (fs)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        col = col_cnt;
        row = row_cnt;
        t0 = window[0]; t1 = window[1]; t2 = row_two_above[col % 1024];
        m0 = window[2]; m2 = row_above[col % 1024];
        b0 = window[4]; b1 = window[5]; b2 = pix;
        row_two_above[col % 1024] = row_above[col % 1024];
        row_above[col % 1024] = pix;
        window[0] = window[1]; window[1] = t2[7:0];
        window[2] = window[3]; window[3] = m2[7:0];
        window[4] = window[5]; window[5] = pix;
        r = '0;
        if (col >= 2 && row >= 2 && col < w && row < h)
        begin
            gx = (t0 + 2 * m0 + b0) - (t2 + 2 * m2 + b2);
            gy = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            lhs = longint'(ay) << 16;
            r.valid_res = 1'b1;
            r.center_col = 10'(col - 1);
            r.center_row = 10'(row - 1);
            r.grad_x = 11'(gx);
            r.grad_y = 11'(gy);
            r.magnitude = 11'(floor_sqrt(ax * ax + ay * ay));
            if (ax == 0 && ay == 0)
                r.sector = SEC_HORIZ;
            else if (lhs < longint'(TAN_LO) * ax)
                r.sector = SEC_HORIZ;
            else if (lhs >= longint'(TAN_HI) * ax)
                r.sector = SEC_VERT;
            else
                r.sector = ((gx < 0) == (gy < 0)) ? SEC_DIAG45 : SEC_DIAG135;
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        if (row >= h)
            row = 0;
        col_cnt = col;
        row_cnt = row;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gradient_t got;
        gradient_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                window[i] = 8'd0;
            col_cnt = 0;
            row_cnt = 0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_WIDTH_REG)
                    width_reg = pwdata[10:0];
                else if (paddr == ADDR_HEIGHT_REG)
                    height_reg = pwdata[10:0];
            end
            if (s_tvalid && s_tready)
                pending_grads = {pending_grads, sobel_step(s_tdata, s_tuser)};
            if (m_tvalid && m_tready)
            begin
                got = gradient_t'(m_tdata);
                if (pending_grads.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    exp_r = pending_grads.pop_front();
                    if (got.valid_res !== exp_r.valid_res)
                        $error("valid_res: expected %0d, got %0d", exp_r.valid_res,
                            got.valid_res);
                    if (got.center_col !== exp_r.center_col)
                        $error("center_col: expected %0d, got %0d", exp_r.center_col,
                            got.center_col);
                    if (got.center_row !== exp_r.center_row)
                        $error("center_row: expected %0d, got %0d", exp_r.center_row,
                            got.center_row);
                    if (got.grad_x !== exp_r.grad_x)
                        $error("grad_x: expected %0d, got %0d", exp_r.grad_x, got.grad_x);
                    if (got.grad_y !== exp_r.grad_y)
                        $error("grad_y: expected %0d, got %0d", exp_r.grad_y, got.grad_y);
                    if (got.magnitude !== exp_r.magnitude)
                        $error("magnitude: expected %0d, got %0d", exp_r.magnitude,
                            got.magnitude);
                    if (got.sector !== exp_r.sector)
                        $error("sector: expected %0d, got %0d", exp_r.sector, got.sector);
                    if (got !== exp_r)
                        mismatches++;
                end
            end
            outstanding = pending_grads.size();
        end
    end

endmodule

>>> tb/sobel_gradient_sector_unit_test.sv
`timescale 1ns / 100ps

module sobel_gradient_sector_unit_test
    import sgs_pkg::*;
();

    localparam int STALL_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // pixel
    logic        s_tuser = 1'b0;   // frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // valid_res, center_col, center_row, grad_x, grad_y, magnitude, sector
    logic [55:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;
    int          sender_gap = 0;
    int          rx_stall = 0;
    int          idle_cycles = 0;

    sobel_gradient_sector_unit dut (.*);

    sobel_gradient_sector_check checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_stall);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[sobel_gradient_sector_unit] ERROR");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [7:0] pix, logic fs);
        while ($urandom_range(99) < sender_gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(255));
            default: return 8'($urandom_range(110, 100));
        endcase
    endfunction

    task automatic run_frames(int w, int h, int gap, int stall, int count, bit open_frame,
                              int restart_pct);
        int fw;
        int fh;
        int pos;
        logic fs;
        fw = (w < 3) ? 3 : ((w > 1024) ? 1024 : w);
        fh = (h < 3) ? 3 : ((h > 1024) ? 1024 : h);
        apb_write(ADDR_WIDTH_REG, 32'(w));
        apb_write(ADDR_HEIGHT_REG, 32'(h));
        sender_gap = gap;
        rx_stall = stall;
        pos = 0;
        for (int i = 0; i < count; i++)
        begin
            fs = 1'b0;
            if (i == 0)
                fs = open_frame;
            else if (pos >= fw * fh || $urandom_range(99) < restart_pct)
                fs = 1'b1;
            if (fs)
                pos = 0;
            send_pixel(pick_pixel(), fs);
            pos++;
        end
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges, corners and flat regions, then a wrap into the next frame
        apb_write(ADDR_WIDTH_REG, 32'd5);
        apb_write(ADDR_HEIGHT_REG, 32'd4);
        for (int i = 0; i < 25; i++)
        begin
            if (i < 20)
                send_pixel(((i % 5 < 2) ? 8'hFF : 8'h00) ^ ((i / 5 == 3) ? 8'hFF : 8'h00),
                    i == 0);
            else
                send_pixel(8'(i * 37), 1'b0);
        end
        drain();

        run_frames(2, 2047, 0, 0, 150, 1'b1, 2);
        run_frames(16, 6, 82, 0, 200, 1'b1, 3);
        // shrink under the running counters without restarting the frame
        run_frames(7, 3, 0, 82, 150, 1'b0, 3);
        run_frames(2047, 0, 26, 26, 20, 1'b1, 0);
        run_frames(9, 5, 26, 26, 150, 1'b1, 5);
        run_frames(1024, 1024, 0, 0, 60, 1'b1, 0);

        if (mismatches == 0)
            $display("[sobel_gradient_sector_unit] OK");
        else
            $display("[sobel_gradient_sector_unit] ERROR");
        $finish;
    end

endmodule
